@@ design/frws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frws_pkg
// Shared types and constants for the frame rate window statistics block.
// ----------------------------------------------------------------------------
package frws_pkg;

    // Ring depth and the widths that follow from it
    localparam int WINDOW_DEPTH = 64;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // Field widths
    localparam int IN_W         = 24;
    localparam int RATE_W       = 28;
    localparam int TIME_W       = 23;
    localparam int SUM_W        = RATE_W + CNT_W;
    localparam int STEP_W       = $clog2(SUM_W);

    localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 4 * RATE_W + TIME_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Output field positions inside tdata
    localparam int NOW_LSB      = 0;
    localparam int MEAN_LSB     = RATE_W;
    localparam int LEAST_LSB    = 2 * RATE_W;
    localparam int MOST_LSB     = 3 * RATE_W;
    localparam int TIME_LSB     = 4 * RATE_W;

    // Rate scale (fps * 256 * 1e6 us) and the stand-in time for 1/60 s
    localparam logic [SUM_W-1:0]  RATE_SCALE      = SUM_W'(256000000);
    localparam logic [TIME_W-1:0] DEFAULT_TIME_US = TIME_W'(16667);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE_DIV,
        ST_WRITE,
        ST_SCAN,
        ST_MEAN_DIV,
        ST_OUT
    } frws_state_t;

endpackage

@@ design/frame_rate_window_stats.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_window_stats
// Per-frame rate, and mean, minimum and maximum of the last WINDOW_DEPTH rates.
// ----------------------------------------------------------------------------
// Processing: rate division, ring write, scan of the written ring entries
//   (1..WINDOW_DEPTH of them), mean division, then the output register.
// Throughput: a new frame time is taken only in idle, once the last result
//   is in the output register; set by the shared radix-2 divider (one
//   quotient bit per cycle, two divisions) and the ring scan through its
//   single read port.
// Reset: asynchronous, active low; ring fill count and write slot return to
//   zero, so the ring reads as empty without a clearing pass.
module frame_rate_window_stats (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [23:0] frame_time_us
    input  logic [frws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [27:0] rate_now, [55:28] rate_mean, [83:56] rate_least,
    // [111:84] rate_most, [134:112] time_used_us, [135] zero
    output logic [frws_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import frws_pkg::*;

    frws_state_t               state_reg, state_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [CNT_W-1:0]          scan_cnt_reg, scan_cnt_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      out_valid_reg, out_valid_next;

    logic [SUM_W-1:0]          dq_reg, dq_next;
    logic [TIME_W-1:0]         rem_reg, rem_next;
    logic [TIME_W-1:0]         div_reg, div_next;
    logic [TIME_W-1:0]         time_reg, time_next;
    logic [RATE_W-1:0]         rate_reg, rate_next;
    logic [RATE_W-1:0]         mean_reg, mean_next;
    logic [RATE_W-1:0]         least_reg, least_next;
    logic [RATE_W-1:0]         most_reg, most_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [OUT_FIELDS_W-1:0]   out_data_reg, out_data_next;

    logic [RATE_W-1:0]         ring_mem [WINDOW_DEPTH];
    logic [RATE_W-1:0]         ring_q;
    logic                      ring_we;
    logic [SLOT_W-1:0]         rd_addr;

    logic [IN_W-1:0]           raw_in;
    logic [TIME_W-1:0]         time_in;
    logic [TIME_W:0]           rem_sh;
    logic                      rem_ge;
    logic [TIME_W-1:0]         rem_step;
    logic [SUM_W-1:0]          dq_step;
    logic                      scan_issue;

    // Input decode: negative or zero time falls back to 1/60 s
    assign raw_in  = s_axis_tdata[IN_W-1:0];
    assign time_in = (raw_in[IN_W-1] || (raw_in == '0)) ? DEFAULT_TIME_US
                                                         : raw_in[TIME_W-1:0];

    // One restoring division step
    assign rem_sh   = {rem_reg, dq_reg[SUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, div_reg});
    assign rem_step = rem_ge ? TIME_W'(rem_sh - {1'b0, div_reg}) : rem_sh[TIME_W-1:0];
    assign dq_step  = {dq_reg[SUM_W-2:0], rem_ge};

    assign scan_issue = (scan_cnt_reg < fill_reg);
    assign rd_addr    = scan_cnt_reg[SLOT_W-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[slot_reg] <= rate_reg;
        end
        ring_q <= ring_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_vld_next    = rd_vld_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        time_next      = time_reg;
        rate_next      = rate_reg;
        mean_next      = mean_reg;
        least_next     = least_reg;
        most_next      = most_reg;
        sum_next       = sum_reg;
        out_data_next  = out_data_reg;
        ring_we        = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    time_next  = time_in;
                    dq_next    = RATE_SCALE;
                    rem_next   = '0;
                    div_next   = time_in;
                    step_next  = '0;
                    state_next = ST_RATE_DIV;
                end
            end
            ST_RATE_DIV, ST_MEAN_DIV:
            begin
                dq_next   = dq_step;
                rem_next  = rem_step;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    if (state_reg == ST_RATE_DIV)
                    begin
                        rate_next  = dq_step[RATE_W-1:0];
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        mean_next  = dq_step[RATE_W-1:0];
                        state_next = ST_OUT;
                    end
                end
            end
            ST_WRITE:
            begin
                ring_we       = 1'b1;
                slot_next     = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                        : slot_reg + 1'b1;
                fill_next     = (fill_reg == CNT_W'(WINDOW_DEPTH)) ? fill_reg
                                                                   : fill_reg + 1'b1;
                scan_cnt_next = '0;
                rd_vld_next   = 1'b0;
                sum_next      = '0;
                least_next    = '1;
                most_next     = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Issue reads while entries remain; fold in each read in the following cycle
                rd_vld_next = scan_issue;
                if (scan_issue)
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    sum_next = sum_reg + SUM_W'(ring_q);
                    if (ring_q < least_reg)
                    begin
                        least_next = ring_q;
                    end
                    if (ring_q > most_reg)
                    begin
                        most_next = ring_q;
                    end
                end
                if (!scan_issue && !rd_vld_reg)
                begin
                    dq_next    = sum_reg;
                    rem_next   = '0;
                    div_next   = TIME_W'(fill_reg);
                    step_next  = '0;
                    state_next = ST_MEAN_DIV;
                end
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {time_reg, most_reg, least_reg, mean_reg, rate_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            scan_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        time_reg     <= time_next;
        rate_reg     <= rate_next;
        mean_reg     <= mean_next;
        least_reg    <= least_next;
        most_reg     <= most_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ design/frws_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frws_checker
// Port-level checks for frame_rate_window_stats, bound to the top level.
// ----------------------------------------------------------------------------
module frws_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [frws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [frws_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import frws_pkg::*;

    logic [RATE_W-1:0] now_f, mean_f, least_f, most_f;
    logic [TIME_W-1:0] time_f;

    assign now_f   = m_axis_tdata[NOW_LSB +: RATE_W];
    assign mean_f  = m_axis_tdata[MEAN_LSB +: RATE_W];
    assign least_f = m_axis_tdata[LEAST_LSB +: RATE_W];
    assign most_f  = m_axis_tdata[MOST_LSB +: RATE_W];
    assign time_f  = m_axis_tdata[TIME_LSB +: TIME_W];

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // One word in flight: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again before work finished");

    // Current rate is inside the window, and the mean lies between the bounds
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (least_f <= mean_f) && (mean_f <= most_f)
                          && (least_f <= now_f) && (now_f <= most_f))
        else $error("window statistics out of order");

    // A used time is never zero, and its rate is never zero
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (time_f != '0) && (now_f != '0))
        else $error("zero time or rate in result");

endmodule

bind frame_rate_window_stats frws_checker u_frws_checker (.*);
